[src/engine_rpm_torque_step_defines.svh]
// ----------------------------------------------------------------------------
// engine_rpm_torque_step_defines.svh
// Assertion macros shared by the engine speed model RTL.
// ----------------------------------------------------------------------------
`ifndef ENGINE_RPM_TORQUE_STEP_DEFINES_SVH
`define ENGINE_RPM_TORQUE_STEP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define ERTS_ASSERT_IMPLY(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("erts assertion failed");

// Next-cycle implication, checked outside reset
`define ERTS_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("erts assertion failed");

`endif

[src/erts_pkg.sv]
// ----------------------------------------------------------------------------
// erts_pkg
// Types and constants of the fixed-point engine speed model.
// ----------------------------------------------------------------------------
package erts_pkg;

  // Field widths
  localparam int RPM_W    = 17;
  localparam int TORQUE_W = 16;
  localparam int DT_W     = 16;
  localparam int THR_W    = 9;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_TORQUE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION_COEF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_INERTIA  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_INERTIA  = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] PEAK_TORQUE_RST   = 16'd4800;
  localparam logic [CFG_W-1:0] FRICTION_COEF_RST = 16'd655;
  localparam logic [CFG_W-1:0] BASE_INERTIA_RST  = 16'd256;
  localparam logic [CFG_W-1:0] LOAD_INERTIA_RST  = 16'd256;

  // Speed breakpoints, 1/16 rpm
  localparam logic [RPM_W-1:0] RPM_MIN     = 17'd12800;
  localparam logic [RPM_W-1:0] RPM_MAX     = 17'd112000;
  localparam logic [RPM_W-1:0] RAMP_END    = 17'd16000;
  localparam logic [RPM_W-1:0] PLATEAU_END = 17'd88000;
  localparam logic [15:0]      RAMP_BASE   = 16'd1600;

  // x/10 = (x*52429) >> 19 and x/5 = (x*52429) >> 18, exact for 16-bit x
  localparam logic [15:0] RECIP10 = 16'd52429;

  // 60/(2*pi) in Q16
  localparam int GAIN_W = 20;
  localparam logic [GAIN_W-1:0] RPM_GAIN_Q16 = 20'd625823;

  // Serial arithmetic unit sizes
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 20;
  localparam int DIV_D_W = 16;
  localparam int DIV_Q_W = 18;

  typedef struct packed {
    logic              req_type;
    logic [DT_W-1:0]   step_dt;
    logic [THR_W-1:0]  throttle;
    logic [RPM_W-1:0]  rpm_value;
  } req_t;

  typedef struct packed {
    logic [RPM_W-1:0]           rpm_out;
    logic signed [TORQUE_W-1:0] torque_out;
  } rsp_t;

endpackage

[src/erts_stream_if.sv]
// ----------------------------------------------------------------------------
// erts_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface erts_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[src/erts_mul.sv]
// ----------------------------------------------------------------------------
// erts_mul
// Radix-4 serial shift-add multiplier; finishes once the multiplier
// operand has shifted out to zero.
// ----------------------------------------------------------------------------
module erts_mul import erts_pkg::*; #(
  parameter int A_W = MUL_A_W,
  parameter int B_W = MUL_B_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output logic                 done,
  output logic [A_W+B_W-1:0]   product
);

  localparam int P_W = A_W + B_W;

  logic           busy;
  logic [B_W-1:0] b_sh;
  logic [P_W-1:0] a1_sh;
  logic [P_W-1:0] a3_sh;
  logic [P_W-1:0] acc;
  logic [P_W-1:0] addend;

  // partial product for the current 2-bit digit
  always_comb begin
    unique case (b_sh[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = a1_sh;
      2'd2:    addend = a1_sh << 1;
      default: addend = a3_sh;
    endcase
  end

  // shift-add sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      b_sh  <= b;
      a1_sh <= P_W'(a);
      a3_sh <= P_W'(a) + (P_W'(a) << 1);
      acc   <= '0;
    end else if (busy) begin
      if (b_sh == '0) begin
        busy <= 1'b0;
      end else begin
        acc   <= acc + addend;
        a1_sh <= a1_sh << 2;
        a3_sh <= a3_sh << 2;
        b_sh  <= b_sh >> 2;
      end
    end
  end

  assign done    = busy && (b_sh == '0);
  assign product = acc;

endmodule

[src/erts_div.sv]
// ----------------------------------------------------------------------------
// erts_div
// Restoring divider, one quotient bit per cycle. The high part of the
// dividend must already be below the divisor.
// ----------------------------------------------------------------------------
module erts_div import erts_pkg::*; #(
  parameter int D_W = DIV_D_W,
  parameter int Q_W = DIV_Q_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [D_W-1:0] num_hi,
  input  logic [Q_W-1:0] num_lo,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [Q_W-1:0] quot
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [Q_W-1:0]   q_sh;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             ge;

  // trial subtraction for the next bit
  always_comb begin
    trial = {rem, q_sh[Q_W-1]};
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
  end

  // quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(Q_W);
      rem  <= num_hi;
      q_sh <= num_lo;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        rem  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
        q_sh <= {q_sh[Q_W-2:0], ge};
        cnt  <= cnt - 1'b1;
      end
    end
  end

  assign done = busy && (cnt == '0);
  assign quot = q_sh;

endmodule

[src/engine_rpm_torque_step.sv]
// A load transaction goes from acceptance through S_OUT into the output register;
// an advance transaction runs setup (S_RECIP, S_AVAIL), radix-4 multiplies
// (throttle, friction gain, step length, gain constant), a divide (skipped when
// the quotient overflows), update, output.
// One transaction in flight; the next is taken the cycle after the result is
// registered, and a full output register holds it back. Reset (rst, sync): defaults.
// ----------------------------------------------------------------------------
// engine_rpm_torque_step
// Fixed-point engine speed model: torque curve, throttle, friction, inertia.
// ----------------------------------------------------------------------------
`include "engine_rpm_torque_step_defines.svh"

module engine_rpm_torque_step import erts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  erts_stream_if.sink          req,
  erts_stream_if.source        rsp
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RECIP = 4'd1;
  localparam logic [3:0] S_AVAIL = 4'd2;
  localparam logic [3:0] S_DRIVE = 4'd3;
  localparam logic [3:0] S_FRIC  = 4'd4;
  localparam logic [3:0] S_MAGDT = 4'd5;
  localparam logic [3:0] S_GAIN  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam int P_W   = MUL_A_W + MUL_B_W;
  localparam int SUM_W = DIV_Q_W + 2;

  logic [3:0]                 state;
  logic [CFG_W-1:0]           plat_torque;
  logic [CFG_W-1:0]           fric_gain;
  logic [CFG_W-1:0]           min_inertia;
  logic [CFG_W-1:0]           load_inertia;
  logic [RPM_W-1:0]           engine_rpm;
  logic signed [TORQUE_W-1:0] net_torque;
  logic [DT_W-1:0]            step_dt;
  logic [THR_W-1:0]           throttle;
  logic [31:0]                recip_prod;
  logic [RPM_W-1:0]           drive;
  logic                       neg;
  logic [DIV_Q_W-1:0]         quot;
  logic                       out_valid;
  logic                       out_load;
  rsp_t                       out_data;

  logic                       mul_start;
  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic                       mul_done;
  logic [P_W-1:0]             mul_prod;
  logic                       div_start;
  logic                       div_done;
  logic [DIV_Q_W-1:0]         div_quot;

  logic [RPM_W-1:0]           rpm_off;
  logic [15:0]                recip_in;
  logic [15:0]                ramp_val;
  logic [13:0]                decay_sub;
  logic [15:0]                decay_val;
  logic [15:0]                avail;
  logic signed [RPM_W:0]      net_wide;
  logic signed [TORQUE_W-1:0] net_sat;
  logic [TORQUE_W:0]          mag_wide;
  logic [15:0]                mag;
  logic [CFG_W-1:0]           inertia;
  logic [27:0]                scaled;
  logic                       ovf;
  logic signed [SUM_W-1:0]    rpm_sum;
  logic [RPM_W-1:0]           rpm_clamped;

  // available torque from the speed curve
  always_comb begin
    rpm_off   = engine_rpm - PLATEAU_END;
    recip_in  = (engine_rpm < RAMP_END) ? engine_rpm[15:0] : rpm_off[15:0];
    ramp_val  = RAMP_BASE + 16'(recip_prod[31:19]);
    decay_sub = recip_prod[31:18];
    decay_val = (plat_torque >= 16'(decay_sub)) ? plat_torque - 16'(decay_sub) : '0;
    priority if (engine_rpm < RAMP_END) begin
      avail = ramp_val;
    end else if (engine_rpm < PLATEAU_END) begin
      avail = plat_torque;
    end else begin
      avail = decay_val;
    end
  end

  // net torque, saturated, and its magnitude
  always_comb begin
    net_wide = $signed({1'b0, drive}) - $signed({1'b0, mul_prod[32:16]});
    priority if (net_wide > $signed((RPM_W+1)'(32767))) begin
      net_sat = 16'sh7fff;
    end else if (net_wide < -$signed((RPM_W+1)'(32768))) begin
      net_sat = 16'sh8000;
    end else begin
      net_sat = net_wide[TORQUE_W-1:0];
    end
    mag_wide = net_sat[TORQUE_W-1] ? -{net_sat[TORQUE_W-1], net_sat}
                                   : {1'b0, net_sat};
    mag      = mag_wide[15:0];
  end

  // effective inertia and divide overflow check
  always_comb begin
    inertia = (load_inertia > min_inertia) ? load_inertia : min_inertia;
    if (inertia == '0) begin
      inertia = 16'd1;
    end
    scaled = mul_prod[51:24];
    ovf    = ({6'd0, scaled[27:18]} >= inertia);
  end

  // speed update with clamp
  always_comb begin
    rpm_sum = neg ? $signed(SUM_W'(engine_rpm)) - $signed(SUM_W'(quot))
                  : $signed(SUM_W'(engine_rpm)) + $signed(SUM_W'(quot));
    priority if (rpm_sum < $signed(SUM_W'(RPM_MIN))) begin
      rpm_clamped = RPM_MIN;
    end else if (rpm_sum > $signed(SUM_W'(RPM_MAX))) begin
      rpm_clamped = RPM_MAX;
    end else begin
      rpm_clamped = rpm_sum[RPM_W-1:0];
    end
  end

  // multiplier operand select
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_AVAIL: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(avail);
        mul_b     = MUL_B_W'(throttle);
      end
      S_DRIVE: begin
        mul_start = mul_done;
        mul_a     = MUL_A_W'(engine_rpm);
        mul_b     = MUL_B_W'(fric_gain);
      end
      S_FRIC: begin
        mul_start = mul_done;
        mul_a     = MUL_A_W'(mag);
        mul_b     = MUL_B_W'(step_dt);
      end
      S_MAGDT: begin
        mul_start = mul_done;
        mul_a     = mul_prod[MUL_A_W-1:0];
        mul_b     = RPM_GAIN_Q16;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  assign div_start = (state == S_GAIN) && mul_done && !ovf;

  erts_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  erts_div #(
    .D_W (DIV_D_W),
    .Q_W (DIV_Q_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_hi ({6'd0, scaled[27:18]}),
    .num_lo (scaled[17:0]),
    .den    (inertia),
    .done   (div_done),
    .quot   (div_quot)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      plat_torque  <= PEAK_TORQUE_RST;
      fric_gain    <= FRICTION_COEF_RST;
      min_inertia  <= BASE_INERTIA_RST;
      load_inertia <= LOAD_INERTIA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PEAK_TORQUE:   plat_torque  <= cfg_data;
        REG_FRICTION_COEF: fric_gain    <= cfg_data;
        REG_BASE_INERTIA:  min_inertia  <= cfg_data;
        default:           load_inertia <= cfg_data;
      endcase
    end
  end

  // result register loads when empty or draining this cycle
  assign out_load = (state == S_OUT) && (!out_valid || rsp.ready);

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // step sequencer and model state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      engine_rpm <= RPM_MIN;
      net_torque <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            step_dt  <= req.data.step_dt;
            throttle <= req.data.throttle;
            if (req.data.req_type) begin
              engine_rpm <= req.data.rpm_value;
              state      <= S_OUT;
            end else begin
              state <= S_RECIP;
            end
          end
        end
        S_RECIP: begin
          recip_prod <= 32'(recip_in) * 32'(RECIP10);
          state      <= S_AVAIL;
        end
        S_AVAIL: begin
          state <= S_DRIVE;
        end
        S_DRIVE: begin
          if (mul_done) begin
            drive <= mul_prod[24:8];
            state <= S_FRIC;
          end
        end
        S_FRIC: begin
          if (mul_done) begin
            net_torque <= net_sat;
            neg        <= net_sat[TORQUE_W-1];
            state      <= S_MAGDT;
          end
        end
        S_MAGDT: begin
          if (mul_done) begin
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (mul_done) begin
            if (ovf) begin
              // quotient beyond the speed range: saturate, the clamp decides
              quot  <= '1;
              state <= S_UPD;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            quot  <= div_quot;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          engine_rpm <= rpm_clamped;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_data.rpm_out    <= engine_rpm;
            out_data.torque_out <= net_torque;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  `ERTS_ASSERT_NEXT(a_rpm_clamped, clk, rst, state == S_UPD, (engine_rpm >= RPM_MIN) && (engine_rpm <= RPM_MAX))
  `ERTS_ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)
  `ERTS_ASSERT_IMPLY(a_mul_done_waited, clk, rst, mul_done, (state == S_DRIVE) || (state == S_FRIC) || (state == S_MAGDT) || (state == S_GAIN))
  `ERTS_ASSERT_IMPLY(a_div_done_waited, clk, rst, div_done, state == S_DIV)

endmodule
